/* sv/rpa_pkg.sv */
// Shared types, operation and status codes, and register constants for the register pool allocator.
`default_nettype none
package rpa_pkg;

	localparam int REG_W      = 4;
	localparam int OP_W       = 3;
	localparam int STATUS_W   = 2;
	localparam int SAVE_DEPTH = 5;
	localparam int COUNT_W    = 3;
	localparam int ORDER_PLAIN_LEN  = 7;
	localparam int ORDER_ACROSS_LEN = 5;

	localparam logic [OP_W-1:0] OP_RESERVE = 3'd0;
	localparam logic [OP_W-1:0] OP_TRY     = 3'd1;
	localparam logic [OP_W-1:0] OP_ALLOC   = 3'd2;
	localparam logic [OP_W-1:0] OP_RELEASE = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;

	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_CONFLICT  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_TAKEN = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd3;

	localparam logic [REG_W-1:0] XR_RBX = 4'd3;
	localparam logic [REG_W-1:0] XR_RSI = 4'd6;
	localparam logic [REG_W-1:0] XR_RDI = 4'd7;
	localparam logic [REG_W-1:0] XR_R8  = 4'd8;
	localparam logic [REG_W-1:0] XR_R9  = 4'd9;
	localparam logic [REG_W-1:0] XR_R12 = 4'd12;
	localparam logic [REG_W-1:0] XR_R13 = 4'd13;
	localparam logic [REG_W-1:0] XR_R14 = 4'd14;
	localparam logic [REG_W-1:0] XR_R15 = 4'd15;

	localparam logic [REG_W-1:0] ORDER_PLAIN [ORDER_PLAIN_LEN] =
		'{XR_R8, XR_R9, XR_RBX, XR_R12, XR_R13, XR_R14, XR_R15};
	localparam logic [REG_W-1:0] ORDER_ACROSS [ORDER_ACROSS_LEN] =
		'{XR_RBX, XR_R12, XR_R13, XR_R14, XR_R15};

	typedef logic [SAVE_DEPTH-1:0][REG_W-1:0] save_list_t;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [REG_W-1:0] reg_number;
		logic             over_call;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]         status;
		logic [REG_W-1:0]            granted_reg;
		logic                        was_used;
		logic [COUNT_W-1:0]          save_count;
		logic [SAVE_DEPTH*REG_W-1:0] save_order;
	} res_t;

	function automatic logic is_preserved_reg(input logic [REG_W-1:0] r);
		return r inside {XR_RBX, XR_R12, XR_R13, XR_R14, XR_R15};
	endfunction

	function automatic logic is_releasable(input logic [REG_W-1:0] r);
		return r inside {XR_RDI, XR_RSI, XR_R8, XR_R9} || is_preserved_reg(r);
	endfunction

endpackage
`default_nettype wire

/* sv/rpa_step.sv */
// Combinational logic for one request: result fields and the next pool and saved-list state.
`default_nettype none
module rpa_step #(
	parameter int NUM_REGS = 16
) (
	input  wire rpa_pkg::req_t                     req,
	input  wire logic [NUM_REGS-1:0]               busy,
	input  wire rpa_pkg::save_list_t               list,
	input  wire logic [rpa_pkg::COUNT_W-1:0]       count,
	output rpa_pkg::res_t                          res,
	output logic [NUM_REGS-1:0]                    busy_next,
	output rpa_pkg::save_list_t                    list_next,
	output logic [rpa_pkg::COUNT_W-1:0]            count_next
);

	localparam int IDX_W = $clog2(NUM_REGS);

	logic                         prior;
	logic                         take_en;
	logic [rpa_pkg::REG_W-1:0]    take_reg;
	logic                         alloc_found;
	logic [rpa_pkg::REG_W-1:0]    alloc_reg;
	logic                         on_list;
	logic [rpa_pkg::STATUS_W-1:0] status_c;
	logic [rpa_pkg::REG_W-1:0]    granted_c;
	logic                         was_used_c;
	logic [rpa_pkg::SAVE_DEPTH*rpa_pkg::REG_W-1:0] packed_order;

	assign prior = busy[req.reg_number[IDX_W-1:0]];

	// Walk the priority order from the back so that the earliest free entry wins.
	always_comb begin
		alloc_found = 1'b0;
		alloc_reg   = '0;
		if (req.over_call) begin
			for (int i = rpa_pkg::ORDER_ACROSS_LEN - 1; i >= 0; i--) begin
				if (!busy[rpa_pkg::ORDER_ACROSS[i][IDX_W-1:0]]) begin
					alloc_found = 1'b1;
					alloc_reg   = rpa_pkg::ORDER_ACROSS[i];
				end
			end
		end else begin
			for (int i = rpa_pkg::ORDER_PLAIN_LEN - 1; i >= 0; i--) begin
				if (!busy[rpa_pkg::ORDER_PLAIN[i][IDX_W-1:0]]) begin
					alloc_found = 1'b1;
					alloc_reg   = rpa_pkg::ORDER_PLAIN[i];
				end
			end
		end
	end

	always_comb begin
		take_en    = 1'b0;
		take_reg   = req.reg_number;
		busy_next  = busy;
		status_c   = rpa_pkg::ST_DONE;
		granted_c  = req.reg_number;
		was_used_c = prior;
		case (req.operation)
			rpa_pkg::OP_RESERVE: begin
				if (prior) status_c = rpa_pkg::ST_CONFLICT;
				else       take_en = 1'b1;
			end
			rpa_pkg::OP_TRY: begin
				if (prior) status_c = rpa_pkg::ST_NOT_TAKEN;
				else       take_en = 1'b1;
			end
			rpa_pkg::OP_ALLOC: begin
				was_used_c = 1'b0;
				take_reg   = alloc_reg;
				if (alloc_found) begin
					take_en   = 1'b1;
					granted_c = alloc_reg;
				end else begin
					status_c  = rpa_pkg::ST_EXHAUSTED;
					granted_c = '0;
				end
			end
			rpa_pkg::OP_RELEASE: begin
				if (rpa_pkg::is_releasable(req.reg_number))
					busy_next[req.reg_number[IDX_W-1:0]] = 1'b0;
			end
			default: begin
			end
		endcase
		if (take_en)
			busy_next[take_reg[IDX_W-1:0]] = 1'b1;
	end

	// A callee-saved register goes on the list the first time it is taken.
	always_comb begin
		on_list = 1'b0;
		for (int i = 0; i < rpa_pkg::SAVE_DEPTH; i++) begin
			if (rpa_pkg::COUNT_W'(i) < count && list[i] == take_reg)
				on_list = 1'b1;
		end
		list_next  = list;
		count_next = count;
		if (take_en && rpa_pkg::is_preserved_reg(take_reg) && !on_list &&
		    count < rpa_pkg::COUNT_W'(rpa_pkg::SAVE_DEPTH)) begin
			for (int i = 0; i < rpa_pkg::SAVE_DEPTH; i++) begin
				if (rpa_pkg::COUNT_W'(i) == count)
					list_next[i] = take_reg;
			end
			count_next = count + 1'b1;
		end
	end

	always_comb begin
		packed_order = '0;
		for (int i = 0; i < rpa_pkg::SAVE_DEPTH; i++) begin
			if (rpa_pkg::COUNT_W'(i) < count_next)
				packed_order[i*rpa_pkg::REG_W +: rpa_pkg::REG_W] = list_next[i];
		end
	end

	assign res = {status_c, granted_c, was_used_c, count_next, packed_order};

endmodule
`default_nettype wire

/* sv/register_pool_allocator.sv */
// Top level of the register pool allocator: request register, state, result register.
// Usage
//   A request (operation, reg_number, over_call) is taken on the input channel
//   when in_valid and in_ready are both high. Each request yields exactly one
//   result (status, granted_reg, was_used, save_count, save_order) on the output
//   channel, delivered when out_valid and out_ready are both high.
//   A request accepted into the request register passes on to the result register
//   and is presented from there as its result. Throughput is one request per
//   cycle while the receiver does not stall; the read-modify-write of the busy
//   bits and the saved list is done for each request between the request
//   register and the result register.
//   When the receiver stalls, the result register holds its contents and the
//   request register still takes one more request; in_ready then falls until
//   the result is taken. State only changes as a request moves on to the
//   result register, so requests are applied strictly in order.
//   Reset clears all busy bits, the saved count and both valid flags; the saved
//   list entries are not cleared, since only entries below the count are shown.
`default_nettype none
module register_pool_allocator #(
	parameter int NUM_REGS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  operation,
	input  wire logic [3:0]  reg_number,
	input  wire logic        over_call,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [3:0]       granted_reg,
	output logic             was_used,
	output logic [2:0]       save_count,
	output logic [19:0]      save_order
);

	rpa_pkg::req_t                  req_s1;
	logic                           valid_s1;
	rpa_pkg::res_t                  res_s2;
	logic                           valid_s2;
	logic [NUM_REGS-1:0]            busy_q;
	rpa_pkg::save_list_t            list_q;
	logic [rpa_pkg::COUNT_W-1:0]    count_q;

	rpa_pkg::res_t                  step_res;
	logic [NUM_REGS-1:0]            busy_next;
	rpa_pkg::save_list_t            list_next;
	logic [rpa_pkg::COUNT_W-1:0]    count_next;
	logic                           advance;
	logic                           commit;

	assign advance  = !valid_s2 || out_ready;
	assign commit   = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	rpa_step #(
		.NUM_REGS(NUM_REGS)
	) u_step (
		.req       (req_s1),
		.busy      (busy_q),
		.list      (list_q),
		.count     (count_q),
		.res       (step_res),
		.busy_next (busy_next),
		.list_next (list_next),
		.count_next(count_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			busy_q   <= '0;
			count_q  <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= valid_s1;
			if (commit) begin
				busy_q  <= busy_next;
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.operation  <= operation;
			req_s1.reg_number <= reg_number;
			req_s1.over_call  <= over_call;
		end
		if (commit) begin
			res_s2 <= step_res;
			list_q <= list_next;
		end
	end

	assign out_valid   = valid_s2;
	assign status      = res_s2.status;
	assign granted_reg = res_s2.granted_reg;
	assign was_used    = res_s2.was_used;
	assign save_count  = res_s2.save_count;
	assign save_order  = res_s2.save_order;

	// A successful allocation leaves its chosen register busy.
	a_alloc_marks_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && req_s1.operation == rpa_pkg::OP_ALLOC &&
		 step_res.status == rpa_pkg::ST_DONE)
		|=> busy_q[$past(step_res.granted_reg)])
		else $error("allocated register not marked busy");

	// The saved list only ever grows.
	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= $past(count_q))
		else $error("saved count decreased");

	// Pool state moves only when a request passes to the result register.
	a_state_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> ($stable(busy_q) && $stable(count_q)))
		else $error("state changed without a committed request");

	// A refused strict reserve implies the register was already busy.
	a_conflict_was_used: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == rpa_pkg::ST_CONFLICT) |-> was_used)
		else $error("reserve conflict reported on a free register");

endmodule
`default_nettype wire

/* sim/tb.sv */
// Testbench for the register pool allocator: queued random and directed requests, scoreboard check.
module tb;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_REQS = 1950;
	localparam int CALM_FROM   = 800;
	localparam int CALM_TO     = 1200;

	localparam logic [rpa_pkg::REG_W-1:0] REG_RAX = 4'd0;
	localparam logic [rpa_pkg::REG_W-1:0] REG_RSP = 4'd4;
	localparam logic [rpa_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [rpa_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;

	// Allocation priority: plain allocation starts at the first entry, across a call at RBX.
	localparam logic [rpa_pkg::REG_W-1:0] PICK_ORDER [7] =
		'{rpa_pkg::XR_R8, rpa_pkg::XR_R9, rpa_pkg::XR_RBX, rpa_pkg::XR_R12,
		  rpa_pkg::XR_R13, rpa_pkg::XR_R14, rpa_pkg::XR_R15};
	localparam int ACROSS_START = 2;
	localparam logic [rpa_pkg::REG_W-1:0] POOL_REGS [9] =
		'{rpa_pkg::XR_RSI, rpa_pkg::XR_RDI, rpa_pkg::XR_R8, rpa_pkg::XR_R9,
		  rpa_pkg::XR_RBX, rpa_pkg::XR_R12, rpa_pkg::XR_R13, rpa_pkg::XR_R14,
		  rpa_pkg::XR_R15};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] operation = '0;
	logic [3:0] reg_number = '0;
	logic over_call = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [3:0] granted_reg;
	logic was_used;
	logic [2:0] save_count;
	logic [19:0] save_order;

	rpa_pkg::req_t pending_reqs[$];
	rpa_pkg::res_t expected_results[$];
	rpa_pkg::req_t next_req;
	rpa_pkg::req_t seen_req;
	rpa_pkg::res_t want;
	logic req_taken = 1'b0;
	int reqs_taken = 0;
	int err_count = 0;
	int stall_cycles = 0;

	// Shadow state of the pool.
	logic [15:0] busy_map = '0;
	logic [rpa_pkg::REG_W-1:0] saved_regs [rpa_pkg::SAVE_DEPTH];
	logic [rpa_pkg::COUNT_W-1:0] saved_num = '0;

	register_pool_allocator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.reg_number(reg_number),
		.over_call(over_call),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.granted_reg(granted_reg),
		.was_used(was_used),
		.save_count(save_count),
		.save_order(save_order)
	);

	always #5 clk = ~clk;

	function automatic void mark_taken(logic [rpa_pkg::REG_W-1:0] r);
		logic listed;
		listed = 1'b0;
		busy_map[r] = 1'b1;
		if (r inside {rpa_pkg::XR_RBX, rpa_pkg::XR_R12, rpa_pkg::XR_R13, rpa_pkg::XR_R14,
				rpa_pkg::XR_R15}) begin
			for (int i = 0; i < saved_num; i++)
				if (saved_regs[i] == r)
					listed = 1'b1;
			if (!listed && saved_num < rpa_pkg::SAVE_DEPTH) begin
				saved_regs[saved_num] = r;
				saved_num = saved_num + 1'b1;
			end
		end
	endfunction

	function automatic rpa_pkg::res_t apply_request(rpa_pkg::req_t r);
		rpa_pkg::res_t res;
		logic found;
		res.status = rpa_pkg::ST_DONE;
		res.granted_reg = r.reg_number;
		res.was_used = busy_map[r.reg_number];
		case (r.operation)
			rpa_pkg::OP_RESERVE, rpa_pkg::OP_TRY: begin
				if (res.was_used)
					res.status = (r.operation == rpa_pkg::OP_RESERVE) ?
						rpa_pkg::ST_CONFLICT : rpa_pkg::ST_NOT_TAKEN;
				else
					mark_taken(r.reg_number);
			end
			rpa_pkg::OP_ALLOC: begin
				found = 1'b0;
				res.was_used = 1'b0;
				res.status = rpa_pkg::ST_EXHAUSTED;
				res.granted_reg = '0;
				for (int i = r.over_call ? ACROSS_START : 0; i < 7; i++)
					if (!found && !busy_map[PICK_ORDER[i]]) begin
						found = 1'b1;
						mark_taken(PICK_ORDER[i]);
						res.granted_reg = PICK_ORDER[i];
						res.status = rpa_pkg::ST_DONE;
					end
			end
			rpa_pkg::OP_RELEASE: begin
				if (r.reg_number inside {rpa_pkg::XR_RDI, rpa_pkg::XR_RSI, rpa_pkg::XR_R8,
						rpa_pkg::XR_R9, rpa_pkg::XR_RBX, rpa_pkg::XR_R12, rpa_pkg::XR_R13,
						rpa_pkg::XR_R14, rpa_pkg::XR_R15})
					busy_map[r.reg_number] = 1'b0;
			end
			default: ;
		endcase
		res.save_count = saved_num;
		res.save_order = '0;
		for (int i = 0; i < saved_num; i++)
			res.save_order[4*i +: 4] = saved_regs[i];
		return res;
	endfunction

	function automatic void add_req(logic [rpa_pkg::OP_W-1:0] op,
			logic [rpa_pkg::REG_W-1:0] r, logic across);
		rpa_pkg::req_t q;
		q.operation = op;
		q.reg_number = r;
		q.over_call = across;
		pending_reqs = {pending_reqs, q};
	endfunction

	function automatic logic calm();
		return reqs_taken >= CALM_FROM && reqs_taken < CALM_TO;
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			out_ready <= calm() || $urandom_range(0, 99) >= 20;
			if (!in_valid || req_taken) begin
				if (pending_reqs.size() > 0 && (calm() || $urandom_range(0, 99) >= 20)) begin
					next_req = pending_reqs.pop_front();
					in_valid <= 1'b1;
					operation <= next_req.operation;
					reg_number <= next_req.reg_number;
					over_call <= next_req.over_call;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				seen_req.operation = operation;
				seen_req.reg_number = reg_number;
				seen_req.over_call = over_call;
				expected_results = {expected_results, apply_request(seen_req)};
				reqs_taken++;
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding");
					err_count++;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						err_count++;
					end
					if (granted_reg !== want.granted_reg) begin
						$error("granted_reg: expected %0d, got %0d", want.granted_reg,
							granted_reg);
						err_count++;
					end
					if (was_used !== want.was_used) begin
						$error("was_used: expected %0d, got %0d", want.was_used, was_used);
						err_count++;
					end
					if (save_count !== want.save_count) begin
						$error("save_count: expected %0d, got %0d", want.save_count,
							save_count);
						err_count++;
					end
					if (save_order !== want.save_order) begin
						$error("save_order: expected %h, got %h", want.save_order, save_order);
						err_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("tb NOT OK");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		int pick;
		logic [rpa_pkg::REG_W-1:0] r;
		// Fill the pool step by step, then run into conflicts and exhaustion.
		add_req(rpa_pkg::OP_QUERY, rpa_pkg::XR_R15, 1'b0);
		add_req(rpa_pkg::OP_ALLOC, rpa_pkg::XR_R15, 1'b0);
		add_req(rpa_pkg::OP_ALLOC, REG_RAX, 1'b0);
		add_req(rpa_pkg::OP_ALLOC, rpa_pkg::XR_R15, 1'b1);
		add_req(rpa_pkg::OP_RESERVE, rpa_pkg::XR_R12, 1'b0);
		add_req(rpa_pkg::OP_RESERVE, rpa_pkg::XR_R12, 1'b1);
		add_req(rpa_pkg::OP_TRY, rpa_pkg::XR_R12, 1'b0);
		add_req(rpa_pkg::OP_TRY, REG_RAX, 1'b0);
		add_req(rpa_pkg::OP_RELEASE, REG_RAX, 1'b0);
		add_req(rpa_pkg::OP_QUERY, REG_RAX, 1'b0);
		add_req(rpa_pkg::OP_ALLOC, REG_RAX, 1'b1);
		add_req(rpa_pkg::OP_ALLOC, REG_RAX, 1'b0);
		add_req(rpa_pkg::OP_ALLOC, REG_RAX, 1'b1);
		add_req(rpa_pkg::OP_ALLOC, rpa_pkg::XR_R15, 1'b1);
		add_req(rpa_pkg::OP_ALLOC, rpa_pkg::XR_R15, 1'b0);
		add_req(rpa_pkg::OP_RELEASE, rpa_pkg::XR_R8, 1'b0);
		add_req(rpa_pkg::OP_RESERVE, rpa_pkg::XR_RDI, 1'b0);
		add_req(rpa_pkg::OP_RELEASE, rpa_pkg::XR_RDI, 1'b1);
		add_req(rpa_pkg::OP_TRY, rpa_pkg::XR_RSI, 1'b0);
		add_req(rpa_pkg::OP_RELEASE, rpa_pkg::XR_RSI, 1'b0);
		add_req(rpa_pkg::OP_RELEASE, rpa_pkg::XR_RBX, 1'b0);
		add_req(rpa_pkg::OP_ALLOC, REG_RAX, 1'b1);
		add_req(rpa_pkg::OP_RESERVE, REG_RSP, 1'b0);
		add_req(OP_SPARE_FIRST, rpa_pkg::XR_R15, 1'b1);
		add_req(OP_SPARE_LAST, REG_RSP, 1'b0);
		for (int n = 0; n < RANDOM_REQS; n++) begin
			pick = $urandom_range(0, 99);
			// Half of the requests draw their register from the releasable pool, the rest from all sixteen.
			if ($urandom_range(0, 1))
				r = POOL_REGS[$urandom_range(0, 8)];
			else
				r = 4'($urandom_range(0, 15));
			if (pick < 14)
				add_req(rpa_pkg::OP_RESERVE, r, 1'($urandom_range(0, 1)));
			else if (pick < 28)
				add_req(rpa_pkg::OP_TRY, r, 1'($urandom_range(0, 1)));
			else if (pick < 50)
				add_req(rpa_pkg::OP_ALLOC, r, 1'($urandom_range(0, 1)));
			else if (pick < 84)
				add_req(rpa_pkg::OP_RELEASE, r, 1'($urandom_range(0, 1)));
			else if (pick < 95)
				add_req(rpa_pkg::OP_QUERY, r, 1'($urandom_range(0, 1)));
			else
				add_req(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), r,
					1'($urandom_range(0, 1)));
		end
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (4) @(posedge clk);
		if (err_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
